// File: hw/rtl/linear_probe_hash_table_macros.svh
// Assertion macros shared by the hash table modules.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lpht_pkg.sv
// Package with the constants, codes, control structs and hash fold of the hash table.
package lpht_pkg;

  // Parameter defaults.
  localparam int TABLE_SIZE_DEF = 64;
  localparam int KEY_WORDS_DEF  = 2;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed port widths.
  localparam int CMD_BITS    = 2;
  localparam int KEY_BITS    = 32;
  localparam int VAL_BITS    = 32;
  localparam int STS_BITS    = 2;
  localparam int SLOT_BITS   = 6;
  localparam int HASH_BITS   = 32;

  // Command codes.
  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STS_BITS-1:0] STS_OK        = 2'd0;
  localparam logic [STS_BITS-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STS_BITS-1:0] STS_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;        // latch the item and its hash
    logic                clr_step;    // clear the entry at the pointer, advance
    logic                hash_step;   // one step of the home slot reduction
    logic                probe_init;  // pointer to the home slot
    logic                probe_step;  // read at the pointer, advance
    logic                mem_wr;      // write an entry: at the pointer while clearing, else the slot under test
    logic                wr_occ;      // occupied bit written
    logic                cnt_inc;
    logic                cnt_dec;
    logic                finish;      // register a result item
    logic [STS_BITS-1:0] res_status;
    logic                res_slot;    // result carries the slot under test
    logic                res_data;    // result carries the stored value
  } lpht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic                in_bad;      // incoming command code is unused
    logic                in_insert;   // incoming command is an insert
    logic                tbl_full;    // every slot is occupied
    logic                hash_done;   // home slot is ready
    logic [CMD_BITS-1:0] op;          // command of the item at work
    logic                rd_occ;      // slot under test is occupied
    logic                rd_match;    // slot under test holds the key
    logic                probe_last;  // every slot has been visited
    logic                clr_last;    // clearing pass is at the last entry
  } lpht_sts_t;

  // XOR fold of the sign-extended 16-bit key words; words above bit 31 read as zero.
  function automatic logic [HASH_BITS-1:0] hash_fold(input logic [KEY_BITS-1:0] key,
                                                     input int key_words);
    logic [63:0]           wide;
    logic [15:0]           w16;
    logic [HASH_BITS-1:0]  w;
    logic [HASH_BITS-1:0]  acc;
    wide = {32'd0, key};
    acc  = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < key_words) begin
        w16 = wide[16*i +: 16];
        w   = {{16{w16[15]}}, w16};
        acc = acc ^ (HASH_BITS'(i) << 4) ^ (w << 8) ^ w;
      end
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/lpht_ctrl.sv
// Controller state machine that sequences clearing, hashing and probing of the table.
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_cmd_t cmd
);

`include "linear_probe_hash_table_macros.svh"

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_ISSUE = 5'b01000,
    S_PROBE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.mem_wr   = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          priority if (sts.in_bad) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_NOT_FOUND;
          end else if (sts.in_insert && sts.tbl_full) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_FULL;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.probe_step = 1'b1;
        state_nxt      = S_PROBE;
      end
      S_PROBE: begin
        // The slot whose entry was read last cycle is tested here.
        if (sts.op == lpht_pkg::CMD_INSERT) begin
          priority if (!sts.rd_occ) begin
            cmd.mem_wr     = 1'b1;
            cmd.wr_occ     = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_OK;
            cmd.res_slot   = 1'b1;
            state_nxt      = S_IDLE;
          end else if (sts.probe_last) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_FULL;
            state_nxt      = S_IDLE;
          end else begin
            cmd.probe_step = 1'b1;
          end
        end else begin
          priority if (!sts.rd_occ) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else if (sts.rd_match) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_OK;
            cmd.res_slot   = 1'b1;
            cmd.res_data   = 1'b1;
            if (sts.op == lpht_pkg::CMD_REMOVE) begin
              cmd.mem_wr  = 1'b1;
              cmd.cnt_dec = 1'b1;
            end
            state_nxt = S_IDLE;
          end else if (sts.probe_last) begin
            cmd.finish     = 1'b1;
            cmd.res_status = lpht_pkg::STS_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else begin
            cmd.probe_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LPHT_ASSERT_NXT(a_finish_idle, cmd.finish, state_r == S_IDLE, "result not followed by idle")
  `LPHT_ASSERT_IMP(a_load_idle, cmd.load, start && !busy, "item loaded without a start")
  `LPHT_ASSERT_IMP(a_wr_scope, cmd.mem_wr, state_r == S_CLEAR || state_r == S_PROBE,
                   "table written outside clearing or probing")

endmodule

// File: hw/rtl/lpht_dpath.sv
// Datapath of the hash table: slot memory, hash reduction, probe pointer and result registers.
module lpht_dpath #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_WORDS  = lpht_pkg::KEY_WORDS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [lpht_pkg::CMD_BITS-1:0]      in_command,
  input  logic [lpht_pkg::KEY_BITS-1:0]      in_key,
  input  logic [lpht_pkg::VAL_BITS-1:0]      in_value,
  output logic                               out_valid,
  output logic [lpht_pkg::STS_BITS-1:0]      out_status,
  output logic [lpht_pkg::VAL_BITS-1:0]      out_data,
  output logic [lpht_pkg::SLOT_BITS-1:0]     out_slot,
  input  lpht_pkg::lpht_cmd_t                cmd,
  output lpht_pkg::lpht_sts_t                sts
);

`include "linear_probe_hash_table_macros.svh"

  localparam int IW         = $clog2(TABLE_SIZE);
  localparam int CW         = $clog2(TABLE_SIZE + 1);
  localparam int KB         = lpht_pkg::KEY_BITS;
  localparam int VB         = lpht_pkg::VAL_BITS;
  localparam int EW         = 1 + KB + VB;
  localparam bit IS_POW2    = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam logic [KB-1:0] KEY_MASK = (KEY_WORDS >= 2) ? {KB{1'b1}} : KB'(32'h0000_FFFF);
  localparam logic [VB-1:0] VALUE_MASK =
    (VALUE_BITS >= VB) ? {VB{1'b1}} : ((VB'(1) << VALUE_BITS) - VB'(1));
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);

  // Item at work.
  logic [lpht_pkg::CMD_BITS-1:0]  op_r;
  logic [KB-1:0]                  key_r;
  logic [VB-1:0]                  value_r;
  logic [lpht_pkg::HASH_BITS-1:0] hsh_r;

  // Probe control.
  logic [IW-1:0] ptr_r;
  logic [IW-1:0] slot_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] home;
  logic          hash_done;

  // Slot memory: occupied bit, key and value per entry.
  logic [EW-1:0] mem [TABLE_SIZE];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] wr_data;
  logic [IW-1:0] wr_addr;
  logic          rd_occ;
  logic [KB-1:0] rd_key;
  logic [VB-1:0] rd_val;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + IW'(1);
  endfunction

  assign {rd_occ, rd_key, rd_val} = rd_q;
  assign wr_addr = cmd.clr_step ? ptr_r : slot_r;
  assign wr_data = {cmd.wr_occ, key_r, value_r};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[ptr_r];
  end

  // Latch the item and the folded hash of its key.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_command;
      key_r   <= in_key & KEY_MASK;
      value_r <= in_value & VALUE_MASK;
      hsh_r   <= lpht_pkg::hash_fold(in_key & KEY_MASK, KEY_WORDS);
    end
  end

  // Reduction of the hash to a home slot.
  generate
    if (IS_POW2) begin : g_mask
      assign home      = hsh_r[IW-1:0];
      assign hash_done = 1'b1;
    end else begin : g_rem
      localparam int HB = lpht_pkg::HASH_BITS;
      localparam logic [HB-1:0] RECIP     = HB'((64'd1 << HB) / TABLE_SIZE);
      localparam logic [IW:0]   SIZE_W    = (IW + 1)'(TABLE_SIZE);
      localparam logic [1:0]    RED_STEPS = 2'd2;
      logic [2*HB-1:0] prod;
      logic [IW:0]     q_r;
      logic [IW:0]     qm;
      logic [IW:0]     rem_r;
      logic [1:0]      hph_r;

      // The reciprocal gives a quotient that is low by at most one.
      assign prod = (2*HB)'(hsh_r) * (2*HB)'(RECIP);
      // The remainder is below twice the size, so only the low bits of the product matter.
      assign qm   = q_r * SIZE_W;

      always_ff @(posedge clk) begin
        q_r   <= prod[HB +: (IW + 1)];
        rem_r <= hsh_r[IW:0] - qm;
      end

      // Two register stages after the load, then the final compare and subtract.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          hph_r <= '0;
        end else if (cmd.load) begin
          hph_r <= RED_STEPS;
        end else if (cmd.hash_step && (hph_r != '0)) begin
          hph_r <= hph_r - 2'd1;
        end
      end

      assign home      = (rem_r >= SIZE_W) ? IW'(rem_r - SIZE_W) : rem_r[IW-1:0];
      assign hash_done = (hph_r == '0);
    end
  endgenerate

  // Probe pointer, slot under test and visit count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.probe_init) begin
      ptr_r <= home;
    end else if (cmd.clr_step || cmd.probe_step) begin
      ptr_r <= next_slot(ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      n_r <= '0;
    end else if (cmd.probe_step) begin
      n_r    <= n_r + CW'(1);
      slot_r <= ptr_r;
    end
  end

  // Number of occupied slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec && (cnt_r != '0)) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts            = '0;
    sts.in_bad     = (in_command != lpht_pkg::CMD_INSERT) &&
                     (in_command != lpht_pkg::CMD_GET) &&
                     (in_command != lpht_pkg::CMD_REMOVE);
    sts.in_insert  = (in_command == lpht_pkg::CMD_INSERT);
    sts.tbl_full   = (cnt_r == CW'(TABLE_SIZE));
    sts.hash_done  = hash_done;
    sts.op         = op_r;
    sts.rd_occ     = rd_occ;
    sts.rd_match   = (rd_key == key_r);
    sts.probe_last = (n_r == CW'(TABLE_SIZE));
    sts.clr_last   = (ptr_r == LAST_SLOT);
  end

  // Result item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= cmd.res_status;
      out_data   <= cmd.res_data ? rd_val : '0;
      out_slot   <= cmd.res_slot ? lpht_pkg::SLOT_BITS'(slot_r) : '0;
    end
  end

  `LPHT_ASSERT_IMP(a_fill_free, cmd.mem_wr && cmd.wr_occ, !rd_occ, "insert over an occupied slot")
  `LPHT_ASSERT_IMP(a_cnt_room, cmd.cnt_inc, cnt_r != CW'(TABLE_SIZE), "count past table size")
  `LPHT_ASSERT_IMP(a_rm_hit, cmd.cnt_dec, rd_occ && (rd_key == key_r), "remove without a match")

endmodule

// File: hw/rtl/linear_probe_hash_table.sv
// Top level of the linear probing key/value hash table.
// After the accepting edge busy stays high while the home slot is found and k slots are probed
// (k from 1 to TABLE_SIZE, one memory read each), and the result strobe follows in the next
// cycle; the home slot needs a remainder reduction when TABLE_SIZE is not a power of two.
// Unused commands and full-table inserts answer the next cycle with busy low; no stall.
// Reset starts a clearing pass over every slot that holds busy high.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_WORDS  = lpht_pkg::KEY_WORDS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpht_pkg::CMD_BITS-1:0]  in_command,
  input  logic [lpht_pkg::KEY_BITS-1:0]  in_key,
  input  logic [lpht_pkg::VAL_BITS-1:0]  in_value,
  output logic                           out_valid,
  output logic [lpht_pkg::STS_BITS-1:0]  out_status,
  output logic [lpht_pkg::VAL_BITS-1:0]  out_data,
  output logic [lpht_pkg::SLOT_BITS-1:0] out_slot
);

  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  // Sequencer.
  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Table storage and arithmetic.
  lpht_dpath #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_WORDS  (KEY_WORDS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_command (in_command),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_data   (out_data),
    .out_slot   (out_slot),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
